FILE: hw/rtl/mlgr_pkg.sv
package mlgr_pkg;

  localparam int MAX_LEVELS  = 65536;
  localparam int ENERGY_BITS = 32;
  localparam int RATIO_BITS  = 16;

  localparam int INDEX_W = 17;
  localparam int SUM_W   = 33;
  localparam int COUNT_W = 17;
  localparam int MEAN_W  = RATIO_BITS + 1;
  localparam int STEP_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BAND_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_END   = 2'd1;

  localparam logic [INDEX_W-1:0] MAX_INDEX  = INDEX_W'(MAX_LEVELS);
  localparam logic [MEAN_W-1:0]  RATIO_ONE  = MEAN_W'(1) << RATIO_BITS;
  localparam logic [STEP_W-1:0]  RATIO_STEPS = STEP_W'(RATIO_BITS);
  localparam logic [STEP_W-1:0]  MEAN_STEPS  = STEP_W'(MEAN_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_SORT,
    ST_DIV,
    ST_ADV,
    ST_FINISH
  } state_t;

endpackage

FILE: hw/rtl/mean_level_gap_ratio_top.sv
// Channel  Direction  Handshake          Word
// in_      input      in_valid/in_stall  in_energy, in_last_level
// out_     output     out_valid/out_stall mean_ratio, entry_count, flags
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// An item whose center is outside the window passes ST_GAP and ST_ADV; a trivial
// ratio adds ST_SORT, and a gap ratio that is divided also runs ST_DIV: the shared
// restoring divider yields one quotient bit per cycle, 16 bits for a ratio.
// A last level with counted centers runs the divider again for the rounded mean,
// 17 quotient bits, and every last level ends in ST_FINISH to load the output
// register. Reset (rst_n low, synchronous) clears the levels, index, sums and
// flags and sets band_start to 0 and band_end to 65536. A stalled result only holds
// back the next last level; other items keep flowing while it waits.
module mean_level_gap_ratio_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mlgr_pkg::ENERGY_BITS-1:0]   in_energy,
  input  logic                               in_last_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mlgr_pkg::MEAN_W-1:0]        out_mean_ratio,
  output logic [mlgr_pkg::COUNT_W-1:0]       out_entry_count,
  output logic                               out_empty_band,
  output logic                               out_saw_degenerate,
  output logic                               out_saw_out_of_order,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mlgr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mlgr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mlgr_pkg::*;

  state_t state_r, state_nxt;

  logic [15:0]            band_start_r;
  logic [16:0]            band_end_r;
  logic [ENERGY_BITS-1:0] older_r, newer_r, energy_r;
  logic                   last_r;
  logic [INDEX_W-1:0]     level_index_r;
  logic [SUM_W-1:0]       ratio_sum_r;
  logic [COUNT_W-1:0]     ratio_count_r;
  logic                   flag_degen_r, flag_order_r;
  logic [ENERGY_BITS-1:0] gap1_r, gap2_r;
  logic                   center_r;

  // Shared restoring divider.
  logic [ENERGY_BITS-1:0] rem_r, divisor_r;
  logic [MEAN_W-1:0]      dividend_r;
  logic [MEAN_W-1:0]      quo_r;
  logic [STEP_W-1:0]      step_r;
  logic                   mean_mode_r;

  logic                   out_valid_r;
  logic [MEAN_W-1:0]      out_mean_r;
  logic [COUNT_W-1:0]     out_count_r;
  logic                   out_empty_r, out_degen_r, out_order_r;

  logic                   in_accept;
  logic                   out_free;
  logic                   div_last;
  logic [ENERGY_BITS:0]   trial;
  logic                   trial_ge;
  logic [ENERGY_BITS:0]   trial_diff;
  logic [INDEX_W-1:0]     center_idx;
  logic                   is_center;
  logic [ENERGY_BITS-1:0] gap_lo, gap_hi;
  logic [SUM_W-1:0]       mean_num;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign div_last  = (step_r == STEP_W'(1));

  assign trial      = {rem_r, dividend_r[MEAN_W-1]};
  assign trial_ge   = (trial >= {1'b0, divisor_r});
  assign trial_diff = trial - {1'b0, divisor_r};

  assign center_idx = level_index_r - INDEX_W'(1);
  assign is_center  = (level_index_r >= INDEX_W'(2)) && (level_index_r < MAX_INDEX) &&
                      (center_idx >= {1'b0, band_start_r}) && (center_idx < band_end_r);

  assign gap_lo = (gap1_r < gap2_r) ? gap1_r : gap2_r;
  assign gap_hi = (gap1_r < gap2_r) ? gap2_r : gap1_r;

  assign mean_num = ratio_sum_r + SUM_W'(ratio_count_r >> 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_accept) state_nxt = ST_GAP;
      ST_GAP:    state_nxt = is_center ? ST_SORT : ST_ADV;
      ST_SORT:   state_nxt = (gap_hi != '0 && gap_lo < gap_hi) ? ST_DIV : ST_ADV;
      ST_DIV: begin
        if (div_last) state_nxt = mean_mode_r ? ST_FINISH : ST_ADV;
      end
      ST_ADV: begin
        if (!last_r) state_nxt = ST_IDLE;
        else if (ratio_count_r != '0) state_nxt = ST_DIV;
        else state_nxt = ST_FINISH;
      end
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_start_r <= '0;
      band_end_r   <= 17'(MAX_LEVELS);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BAND_START) band_start_r <= cfg_data[15:0];
      else if (cfg_index == REG_BAND_END) band_end_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r       <= '0;
      newer_r       <= '0;
      level_index_r <= '0;
      ratio_sum_r   <= '0;
      ratio_count_r <= '0;
      flag_degen_r  <= 1'b0;
      flag_order_r  <= 1'b0;
      mean_mode_r   <= 1'b0;
      step_r        <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            energy_r <= in_energy;
            last_r   <= in_last_level;
          end
        end
        ST_GAP: begin
          if (level_index_r != '0 && energy_r < newer_r) flag_order_r <= 1'b1;
          gap1_r   <= (newer_r >= older_r) ? newer_r - older_r : '0;
          gap2_r   <= (energy_r >= newer_r) ? energy_r - newer_r : '0;
          center_r <= is_center;
        end
        ST_SORT: begin
          if (gap_hi == '0 || gap_lo >= gap_hi) begin
            // Equal gaps give exactly 1.0; two zero gaps are also flagged.
            ratio_sum_r   <= ratio_sum_r + SUM_W'(RATIO_ONE);
            ratio_count_r <= ratio_count_r + COUNT_W'(1);
            if (gap_hi == '0) flag_degen_r <= 1'b1;
          end else begin
            rem_r       <= gap_lo;
            divisor_r   <= gap_hi;
            dividend_r  <= '0;
            quo_r       <= '0;
            step_r      <= RATIO_STEPS;
            mean_mode_r <= 1'b0;
          end
        end
        ST_DIV: begin
          rem_r      <= trial_ge ? trial_diff[ENERGY_BITS-1:0] : trial[ENERGY_BITS-1:0];
          quo_r      <= {quo_r[MEAN_W-2:0], trial_ge};
          dividend_r <= {dividend_r[MEAN_W-2:0], 1'b0};
          step_r     <= step_r - STEP_W'(1);
          if (div_last && !mean_mode_r) begin
            ratio_sum_r   <= ratio_sum_r + SUM_W'({quo_r[MEAN_W-2:0], trial_ge});
            ratio_count_r <= ratio_count_r + COUNT_W'(1);
          end
        end
        ST_ADV: begin
          older_r <= newer_r;
          newer_r <= energy_r;
          if (level_index_r < MAX_INDEX) level_index_r <= level_index_r + INDEX_W'(1);
          // The quotient is below 2^17, so the top dividend bits already sit
          // below the count and only the low 17 bits need shifting in.
          mean_mode_r <= last_r && (ratio_count_r != '0);
          rem_r       <= ENERGY_BITS'(mean_num[SUM_W-1:MEAN_W]);
          dividend_r  <= mean_num[MEAN_W-1:0];
          divisor_r   <= ENERGY_BITS'(ratio_count_r);
          quo_r       <= '0;
          step_r      <= MEAN_STEPS;
        end
        ST_FINISH: begin
          if (out_free) begin
            older_r       <= '0;
            newer_r       <= '0;
            level_index_r <= '0;
            ratio_sum_r   <= '0;
            ratio_count_r <= '0;
            flag_degen_r  <= 1'b0;
            flag_order_r  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && out_free) begin
      out_mean_r  <= mean_mode_r ? quo_r : '0;
      out_count_r <= ratio_count_r;
      out_empty_r <= (ratio_count_r == '0);
      out_degen_r <= flag_degen_r;
      out_order_r <= flag_order_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_mean_ratio       = out_mean_r;
  assign out_entry_count      = out_count_r;
  assign out_empty_band       = out_empty_r;
  assign out_saw_degenerate   = out_degen_r;
  assign out_saw_out_of_order = out_order_r;

  a_index_sat: assert property (@(posedge clk) disable iff (!rst_n)
    level_index_r <= MAX_INDEX)
    else $error("level index beyond saturation");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ratio_count_r <= level_index_r)
    else $error("more averaged centers than levels seen");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < divisor_r)
    else $error("divider remainder not below divisor");

  a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_band |-> out_mean_ratio == '0 && out_entry_count == '0)
    else $error("empty band with nonzero mean or count");

  a_center_used: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SORT |-> center_r)
    else $error("ratio formed for a level outside the window");

endmodule
